/* rtl/core/toeq_pkg.sv */
`default_nettype none

package toeq_pkg;

   // Depth must be a power of two: entry addresses wrap around the ring.
   localparam int QUEUE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int OCC_W       = ADDR_W + 1;

   localparam int RX_W  = 10;
   localparam int TS_W  = 32;
   localparam int TY_W  = 8;
   localparam int CH_W  = 16;
   localparam int CNT_W = 32;

   typedef enum logic {
      REQ_SCHEDULE = 1'b0,
      REQ_DELIVER  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_SCHEDULED = 2'd0,
      STAT_DELIVERED = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_CMP,
      ST_PUSH_PUT,
      ST_POP_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [RX_W-1:0] receiver;
      logic [TY_W-1:0] type_code;
      logic [CH_W-1:0] content_handle;
   } payload_type;

   typedef struct packed {
      logic [TS_W-1:0] key;
      payload_type     payload;
   } entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
   } mem_req_type;

   typedef struct packed {
      status_type       status;
      entry_type        ev;
      logic [CNT_W-1:0] count;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/toeq_store.sv */
`default_nettype none

module toeq_store (
   input  wire logic                clock,
   input  wire toeq_pkg::mem_req_type mem_req,
   output toeq_pkg::entry_type      rd_data
);

   toeq_pkg::entry_type mem_ff [toeq_pkg::QUEUE_DEPTH];
   toeq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/toeq_ctrl.sv */
`default_nettype none

module toeq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_kind,
   input  wire toeq_pkg::entry_type   req_entry,
   output toeq_pkg::mem_req_type      mem_req,
   input  wire toeq_pkg::entry_type   rd_data,
   output logic                       res_valid,
   input  wire logic                  res_ack,
   output toeq_pkg::result_type       res
);

   localparam int AW = toeq_pkg::ADDR_W;
   localparam int OW = toeq_pkg::OCC_W;

   toeq_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [OW-1:0]        occ_ff, occ_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [toeq_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   toeq_pkg::entry_type  cur_ff, cur_in;
   toeq_pkg::result_type res_ff, res_in;

   logic full, empty, later;

   assign full  = (occ_ff == OW'(toeq_pkg::QUEUE_DEPTH));
   assign empty = (occ_ff == '0);
   assign later = (rd_data.key > cur_ff.key);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         toeq_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == toeq_pkg::REQ_SCHEDULE) begin
                  state_in = (full || empty) ? toeq_pkg::ST_DONE : toeq_pkg::ST_PUSH_CMP;
               end else begin
                  state_in = empty ? toeq_pkg::ST_DONE : toeq_pkg::ST_POP_CMP;
               end
            end
         end
         toeq_pkg::ST_PUSH_CMP: begin
            if (later) begin
               state_in = (pos_ff == AW'(1)) ? toeq_pkg::ST_PUSH_PUT : toeq_pkg::ST_PUSH_CMP;
            end else begin
               state_in = toeq_pkg::ST_DONE;
            end
         end
         toeq_pkg::ST_PUSH_PUT: state_in = toeq_pkg::ST_DONE;
         toeq_pkg::ST_POP_CMP:  state_in = toeq_pkg::ST_DONE;
         toeq_pkg::ST_DONE: begin
            if (res_ack) begin
               state_in = toeq_pkg::ST_IDLE;
            end
         end
         default: state_in = toeq_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in = head_ff;
      occ_in  = occ_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      cur_in  = cur_ff;
      res_in  = res_ff;
      mem_req = '0;
      case (state_ff)
         toeq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_entry;
               res_in = '0;
               res_in.count = cnt_ff;
               if (req_kind == toeq_pkg::REQ_SCHEDULE) begin
                  if (full) begin
                     res_in.status = toeq_pkg::STAT_FULL;
                  end else if (empty) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = head_ff;
                     mem_req.wr_data = req_entry;
                     occ_in          = occ_ff + OW'(1);
                     res_in.status   = toeq_pkg::STAT_SCHEDULED;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff + occ_ff[AW-1:0] - AW'(1);
                     pos_in          = occ_ff[AW-1:0];
                  end
               end else begin
                  if (empty) begin
                     res_in.status = toeq_pkg::STAT_EMPTY;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = head_ff;
                  end
               end
            end
         end
         toeq_pkg::ST_PUSH_CMP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = head_ff + pos_ff;
            if (later) begin
               // shift the later entry one place toward the tail
               mem_req.wr_data = rd_data;
               pos_in          = pos_ff - AW'(1);
               if (pos_ff != AW'(1)) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_ff + pos_ff - AW'(2);
               end
            end else begin
               mem_req.wr_data = cur_ff;
               occ_in          = occ_ff + OW'(1);
               res_in.status   = toeq_pkg::STAT_SCHEDULED;
            end
         end
         toeq_pkg::ST_PUSH_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = head_ff;
            mem_req.wr_data = cur_ff;
            occ_in          = occ_ff + OW'(1);
            res_in.status   = toeq_pkg::STAT_SCHEDULED;
         end
         toeq_pkg::ST_POP_CMP: begin
            head_in       = head_ff + AW'(1);
            occ_in        = occ_ff - OW'(1);
            cnt_in        = cnt_ff + 1'b1;
            res_in.status = toeq_pkg::STAT_DELIVERED;
            res_in.ev     = rd_data;
            res_in.count  = cnt_ff + 1'b1;
         end
         toeq_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= toeq_pkg::ST_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == toeq_pkg::ST_IDLE);
   assign res_valid = (state_ff == toeq_pkg::ST_DONE);
   assign res       = res_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(toeq_pkg::QUEUE_DEPTH))
      else $error("occupancy above depth");

   a_wr_push_only: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == toeq_pkg::ST_IDLE || state_ff == toeq_pkg::ST_PUSH_CMP ||
                         state_ff == toeq_pkg::ST_PUSH_PUT))
      else $error("store written outside a push");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      state_ff == toeq_pkg::ST_POP_CMP |=> occ_ff == $past(occ_ff) - OW'(1))
      else $error("delivery did not drop occupancy");

   a_done_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == toeq_pkg::ST_DONE && res_ack) |=> state_ff == toeq_pkg::ST_IDLE)
      else $error("result handoff did not return to idle");

endmodule

`default_nettype wire

/* rtl/core/timestamp_ordered_event_queue_unit.sv */
// Timestamp-ordered event queue: a stable min-priority queue of up to
// 64 events, kept sorted in a ring-addressed synchronous memory.
// Request channel (req_*): req_type 0 schedules an event (receiver,
// timestamp, event type, content handle), req_type 1 delivers the
// earliest one. Equal timestamps leave in arrival order.
// Result channel (rsp_*): one item per request with status, the
// delivered event fields (zero unless delivered) and the running
// delivered count.
// A delivery reads the head entry and hands it out in ST_POP_CMP; a
// schedule walks back from the tail in ST_PUSH_CMP, shifting each
// queued event with a later timestamp one place by the memory's
// read-compare-write loop, then writes the new event. Full and empty
// cases go straight to ST_DONE. One request is in work at a time; the
// next is taken the cycle after its result enters the output register.
// A stalled receiver holds the result in the output register; the
// next request is still taken and worked on, and its result waits
// until the register frees.
// Reset (synchronous, active high) empties the queue and clears the
// delivered count; the memory itself is not cleared.
`default_nettype none

module timestamp_ordered_event_queue_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [9:0]  req_receiver,
   input  wire logic [31:0] req_timestamp,
   input  wire logic [7:0]  req_event_type,
   input  wire logic [15:0] req_content_handle,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [9:0]       rsp_out_receiver,
   output logic [31:0]      rsp_out_timestamp,
   output logic [7:0]       rsp_out_event_type,
   output logic [15:0]      rsp_out_content_handle,
   output logic [31:0]      rsp_delivered_count
);

   toeq_pkg::entry_type   req_entry;
   toeq_pkg::mem_req_type mem_req;
   toeq_pkg::entry_type   rd_data;
   toeq_pkg::result_type  res;
   logic                  res_valid, res_ack;
   logic                  rsp_valid_ff, rsp_valid_in;
   toeq_pkg::result_type  rsp_ff;

   assign req_entry.key                    = req_timestamp;
   assign req_entry.payload.receiver       = req_receiver;
   assign req_entry.payload.type_code      = req_event_type;
   assign req_entry.payload.content_handle = req_content_handle;

   toeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_type),
      .req_entry (req_entry),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ack   (res_ack),
      .res       (res)
   );

   toeq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign res_ack = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ack) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_out_receiver       = rsp_ff.ev.payload.receiver;
   assign rsp_out_timestamp      = rsp_ff.ev.key;
   assign rsp_out_event_type     = rsp_ff.ev.payload.type_code;
   assign rsp_out_content_handle = rsp_ff.ev.payload.content_handle;
   assign rsp_delivered_count    = rsp_ff.count;

endmodule

`default_nettype wire

/* tb/event_queue_checker.sv */
`default_nettype none

module event_queue_checker
   import toeq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_type,
   input  wire logic [9:0]  req_receiver,
   input  wire logic [31:0] req_timestamp,
   input  wire logic [7:0]  req_event_type,
   input  wire logic [15:0] req_content_handle,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [9:0]  rsp_out_receiver,
   input  wire logic [31:0] rsp_out_timestamp,
   input  wire logic [7:0]  rsp_out_event_type,
   input  wire logic [15:0] rsp_out_content_handle,
   input  wire logic [31:0] rsp_delivered_count,
   output int               mismatches,
   output int               open_count
);

   entry_type        queued_events[$];
   result_type       expected_results[$];
   logic [CNT_W-1:0] delivered_total;

   // Stable insert: a new event lands behind every queued event with an equal key.
   function automatic result_type serve_request(input logic kind, input entry_type ev);
      result_type res;
      int         slot;
      res = '0;
      if (kind == REQ_SCHEDULE) begin
         if (queued_events.size() >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;
         end else begin
            slot = 0;
            while (slot < queued_events.size() && queued_events[slot].key <= ev.key)
               slot++;
            queued_events.insert(slot, ev);
            res.status = STAT_SCHEDULED;
         end
      end else if (queued_events.size() == 0) begin
         res.status = STAT_EMPTY;
      end else begin
         res.ev = queued_events.pop_front();
         delivered_total = delivered_total + 1'b1;
         res.status = STAT_DELIVERED;
      end
      res.count = delivered_total;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      entry_type  incoming;
      if (reset) begin
         queued_events.delete();
         expected_results.delete();
         delivered_total = '0;
         mismatches <= 0;
         open_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (mismatches < 10)
                  $display("[%0t] result item with nothing pending: status %0d",
                           $realtime, rsp_status);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status ||
                   rsp_out_receiver !== want.ev.payload.receiver ||
                   rsp_out_timestamp !== want.ev.key ||
                   rsp_out_event_type !== want.ev.payload.type_code ||
                   rsp_out_content_handle !== want.ev.payload.content_handle ||
                   rsp_delivered_count !== want.count) begin
                  if (mismatches < 10) begin
                     $display("[%0t] mismatch: exp st=%0d rx=%0d ts=%h ty=%h ch=%h cnt=%0d",
                              $realtime, want.status, want.ev.payload.receiver, want.ev.key,
                              want.ev.payload.type_code, want.ev.payload.content_handle,
                              want.count);
                     $display("             got st=%0d rx=%0d ts=%h ty=%h ch=%h cnt=%0d",
                              rsp_status, rsp_out_receiver, rsp_out_timestamp,
                              rsp_out_event_type, rsp_out_content_handle,
                              rsp_delivered_count);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            incoming.key                    = req_timestamp;
            incoming.payload.receiver       = req_receiver;
            incoming.payload.type_code      = req_event_type;
            incoming.payload.content_handle = req_content_handle;
            expected_results.push_back(serve_request(req_type, incoming));
         end
         open_count <= expected_results.size();
      end
   end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
   import toeq_pkg::*;

   localparam int ITEM_TARGET = 400;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_kind_type;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_type           = REQ_SCHEDULE;
   logic [9:0]  req_receiver       = '0;
   logic [31:0] req_timestamp      = '0;
   logic [7:0]  req_event_type     = '0;
   logic [15:0] req_content_handle = '0;
   logic        rsp_ready          = 1'b0;
   logic        calm               = 1'b0;

   wire logic        req_ready;
   wire logic        rsp_valid;
   wire logic [1:0]  rsp_status;
   wire logic [9:0]  rsp_out_receiver;
   wire logic [31:0] rsp_out_timestamp;
   wire logic [7:0]  rsp_out_event_type;
   wire logic [15:0] rsp_out_content_handle;
   wire logic [31:0] rsp_delivered_count;

   int mismatches;
   int open_count;
   int cycle_count = 0;

   timestamp_ordered_event_queue_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_receiver           (req_receiver),
      .req_timestamp          (req_timestamp),
      .req_event_type         (req_event_type),
      .req_content_handle     (req_content_handle),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_out_receiver       (rsp_out_receiver),
      .rsp_out_timestamp      (rsp_out_timestamp),
      .rsp_out_event_type     (rsp_out_event_type),
      .rsp_out_content_handle (rsp_out_content_handle),
      .rsp_delivered_count    (rsp_delivered_count)
   );

   event_queue_checker queue_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_receiver           (req_receiver),
      .req_timestamp          (req_timestamp),
      .req_event_type         (req_event_type),
      .req_content_handle     (req_content_handle),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_out_receiver       (rsp_out_receiver),
      .rsp_out_timestamp      (rsp_out_timestamp),
      .rsp_out_event_type     (rsp_out_event_type),
      .rsp_out_content_handle (rsp_out_content_handle),
      .rsp_delivered_count    (rsp_delivered_count),
      .mismatches             (mismatches),
      .open_count             (open_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= calm || ($urandom_range(99) >= 12);
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("** timestamp_ordered_event_queue_unit: FAILED **");
      $finish;
   end

   task automatic send_request(input req_kind_type kind, input logic [31:0] ts,
                               input logic [9:0] rx, input logic [7:0] ty,
                               input logic [15:0] ch);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_timestamp      <= ts;
      req_receiver       <= rx;
      req_event_type     <= ty;
      req_content_handle <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Keys cluster on a few values so equal timestamps are common.
   function automatic logic [31:0] pick_timestamp();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(15);
         4:       return 32'hFFFF_FFF0 + $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(input req_kind_type kind);
      send_request(kind, pick_timestamp(), 10'($urandom_range(1023)),
                   8'($urandom_range(255)), 16'($urandom_range(65535)));
   endtask

   initial begin
      int               sent;
      int               seg;
      int               len;
      segment_kind_type mode;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(REQ_DELIVER, 32'h0, 10'd0, 8'd0, 16'd0);
      send_request(REQ_SCHEDULE, 32'hFFFF_FFFF, 10'd1023, 8'hFF, 16'hFFFF);
      send_request(REQ_SCHEDULE, 32'h0, 10'd0, 8'h00, 16'h0000);
      send_request(REQ_SCHEDULE, 32'd100, 10'd1, 8'h11, 16'h0001);
      send_request(REQ_SCHEDULE, 32'd100, 10'd2, 8'h22, 16'h0002);
      send_request(REQ_SCHEDULE, 32'd50, 10'd3, 8'h33, 16'h0003);
      send_request(REQ_SCHEDULE, 32'd100, 10'd4, 8'h44, 16'h0004);
      send_request(REQ_SCHEDULE, 32'h0, 10'd5, 8'h55, 16'h0005);
      send_request(REQ_SCHEDULE, 32'hFFFF_FFFF, 10'd6, 8'h66, 16'h0006);
      send_request(REQ_DELIVER, 32'hFFFF_FFFF, 10'd1023, 8'hFF, 16'hFFFF);
      repeat (9) send_random(REQ_DELIVER);

      sent = 0;
      seg  = 0;
      while (sent < ITEM_TARGET) begin
         case (seg)
            0:       mode = SEG_FILL;
            1:       mode = SEG_MIXED;
            2:       mode = SEG_DRAIN;
            default: case ($urandom_range(3))
                        0:       mode = SEG_FILL;
                        1:       mode = SEG_DRAIN;
                        default: mode = SEG_MIXED;
                     endcase
         endcase
         case (mode)
            SEG_FILL:  len = $urandom_range(66, 72);
            SEG_DRAIN: len = $urandom_range(66, 70);
            default:   len = $urandom_range(20, 60);
         endcase
         calm <= (seg == 1) || ($urandom_range(4) == 0);
         for (int k = 0; k < len; k++) begin
            case (mode)
               SEG_FILL:  send_random(REQ_SCHEDULE);
               SEG_DRAIN: send_random(REQ_DELIVER);
               default:   send_random($urandom_range(99) < 55 ? REQ_SCHEDULE : REQ_DELIVER);
            endcase
         end
         sent += len;
         seg++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (QUEUE_DEPTH + 8) @(posedge clock);

      if (mismatches == 0)
         $display("** timestamp_ordered_event_queue_unit: PASSED **");
      else
         $display("** timestamp_ordered_event_queue_unit: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
